/* rtl/core/contact_impulse_resolver_core_macros.svh */
// Assertion macros used by the contact resolver port checker.
`ifndef CONTACT_IMPULSE_RESOLVER_CORE_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contact resolver check failed");

// Consequent must hold in the cycle after the antecedent.
`define CIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contact resolver check failed");

`endif

/* rtl/core/cir_pkg.sv */
// Types, constants and helper functions of the contact impulse resolver.
package cir_pkg;

    localparam int DIV_STEPS = 64;

    typedef logic [1:0] t_status;
    localparam t_status ST_RESOLVED  = 2'd0;
    localparam t_status ST_NO_BODY   = 2'd1;
    localparam t_status ST_IMMOVABLE = 2'd2;

    localparam logic [14:0] RESTITUTION_RST = 15'd10813;
    localparam logic [15:0] ONE_Q14         = 16'd16384;

    // Partial remainder and numerator bits that turn into quotient bits.
    typedef struct packed {
        logic [32:0] rem;
        logic [63:0] nq;
    } t_div;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [46:0]        penx;
        logic [46:0]        peny;
        logic               dneg;
    } t_side;

    // One restoring division step: one quotient bit.
    function automatic t_div div_step(t_div w, logic [32:0] d);
        logic [33:0] top;
        logic [33:0] diff;
        t_div        r;
        top  = {w.rem, w.nq[63]};
        diff = top - {1'b0, d};
        if (top >= {1'b0, d}) begin
            r.rem = diff[32:0];
            r.nq  = {w.nq[62:0], 1'b1};
        end else begin
            r.rem = top[32:0];
            r.nq  = {w.nq[62:0], 1'b0};
        end
        return r;
    endfunction

    // Signed magnitude to saturated 32-bit two's complement.
    function automatic logic [31:0] sat32(logic neg, logic [46:0] m);
        logic [31:0] r;
        if (m == 47'd0) begin
            r = 32'd0;
        end else if (neg) begin
            if (m >= 47'h0_8000_0000) r = 32'h8000_0000;
            else                      r = 32'd0 - m[31:0];
        end else begin
            if (m > 47'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
            else                     r = m[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] abs16(logic signed [15:0] v);
        logic [15:0] r;
        r = v[15] ? 16'd0 - 16'(v) : 16'(v);
        return r;
    endfunction

endpackage

/* rtl/core/contact_impulse_resolver_core.sv */
// Contact impulse resolver; three 64-step restoring dividers set the pipeline depth.
// Throughput is one contact per clock while the output is not stalled.
// A stalled output holds the whole pipeline, but an empty first stage still takes a word.
// Reset (synchronous, active low) clears all valid bits and sets restitution to 0.66.
// Datapath registers are not reset.
module contact_impulse_resolver_core
    import cir_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [14:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // inv_mass_a, inv_mass_b, vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y,
    // penetration, one zero pad bit
    input  logic [255:0] i_s_axis_tdata,
    // body_a_present, body_b_present
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // shift_a_x, shift_a_y, shift_b_x, shift_b_y, impulse_x, impulse_y
    output logic [191:0] o_m_axis_tdata,
    // status
    output logic [1:0]   o_m_axis_tuser
);

    logic [14:0] r_restitution;
    logic        en;
    logic        a_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= RESTITUTION_RST;
        end else if (i_cfg_wr_en) begin
            r_restitution <= i_cfg_wr_data;
        end
    end

    logic r_out_valid;
    logic r_a_valid;
    assign en              = !r_out_valid || i_m_axis_tready;
    assign a_load          = en || !r_a_valid;
    assign o_s_axis_tready = a_load;

    // Stage A: total inverse mass, velocity difference, status.
    logic [31:0]        in_ima, in_imb;
    logic signed [31:0] in_vax, in_vay, in_vbx, in_vby;
    logic [32:0]        in_total;
    t_status            in_status;

    assign in_ima   = i_s_axis_tdata[31:0];
    assign in_imb   = i_s_axis_tdata[63:32];
    assign in_vax   = i_s_axis_tdata[95:64];
    assign in_vay   = i_s_axis_tdata[127:96];
    assign in_vbx   = i_s_axis_tdata[159:128];
    assign in_vby   = i_s_axis_tdata[191:160];
    assign in_total = {1'b0, in_ima} + {1'b0, in_imb};

    always_comb begin
        if (!i_s_axis_tuser[0] || !i_s_axis_tuser[1]) in_status = ST_NO_BODY;
        else if (in_total == 33'd0)                   in_status = ST_IMMOVABLE;
        else                                          in_status = ST_RESOLVED;
    end

    t_status            r_a_status;
    logic [32:0]        r_a_total;
    logic [31:0]        r_a_ima, r_a_imb;
    logic signed [32:0] r_a_dvx, r_a_dvy;
    logic signed [15:0] r_a_nx, r_a_ny;
    logic [30:0]        r_a_pen;
    logic [15:0]        r_a_fac;

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_status <= in_status;
            r_a_total  <= in_total;
            r_a_ima    <= in_ima;
            r_a_imb    <= in_imb;
            r_a_dvx    <= 33'(in_vbx) - 33'(in_vax);
            r_a_dvy    <= 33'(in_vby) - 33'(in_vay);
            r_a_nx     <= i_s_axis_tdata[207:192];
            r_a_ny     <= i_s_axis_tdata[223:208];
            r_a_pen    <= i_s_axis_tdata[254:224];
            r_a_fac    <= ONE_Q14 + {1'b0, r_restitution};
        end
    end

    // Stage B: velocity terms of the dot product, penetration times normal.
    logic signed [48:0] b_px, b_py;
    assign b_px = r_a_dvx * r_a_nx;
    assign b_py = r_a_dvy * r_a_ny;

    logic               r_b_valid;
    t_status            r_b_status;
    logic [32:0]        r_b_total;
    logic [31:0]        r_b_ima, r_b_imb;
    logic signed [48:0] r_b_px, r_b_py;
    logic signed [15:0] r_b_nx, r_b_ny;
    logic [46:0]        r_b_penx, r_b_peny;
    logic [15:0]        r_b_fac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_status <= r_a_status;
            r_b_total  <= r_a_total;
            r_b_ima    <= r_a_ima;
            r_b_imb    <= r_a_imb;
            r_b_px     <= b_px;
            r_b_py     <= b_py;
            r_b_nx     <= r_a_nx;
            r_b_ny     <= r_a_ny;
            r_b_penx   <= abs16(r_a_nx) * r_a_pen;
            r_b_peny   <= abs16(r_a_ny) * r_a_pen;
            r_b_fac    <= r_a_fac;
        end
    end

    // Stage C: dot product, split into sign and magnitude.
    logic signed [49:0] c_dot;
    logic [49:0]        c_abs;
    assign c_dot = r_b_px + r_b_py;
    assign c_abs = c_dot[49] ? 50'd0 - 50'(c_dot) : 50'(c_dot);

    logic        r_c_valid;
    t_side       r_c_side;
    logic [32:0] r_c_total;
    logic [31:0] r_c_ima, r_c_imb;
    logic [48:0] r_c_magdot;
    logic [15:0] r_c_fac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side.status <= r_b_status;
            r_c_side.nx     <= r_b_nx;
            r_c_side.ny     <= r_b_ny;
            r_c_side.penx   <= r_b_penx;
            r_c_side.peny   <= r_b_peny;
            r_c_side.dneg   <= c_dot[49];
            r_c_total       <= r_b_total;
            r_c_ima         <= r_b_ima;
            r_c_imb         <= r_b_imb;
            r_c_magdot      <= c_abs[48:0];
            r_c_fac         <= r_b_fac;
        end
    end

    // Stage D loads the dividers; each further stage resolves one quotient bit.
    logic [64:0] d_num;
    assign d_num = r_c_magdot * r_c_fac;

    logic [DIV_STEPS:0] r_dv;
    t_side       r_ds  [0:DIV_STEPS];
    logic [32:0] r_dd  [0:DIV_STEPS];
    t_div        r_dj  [0:DIV_STEPS];
    t_div        r_dsa [0:DIV_STEPS];
    t_div        r_dsb [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ds[0]      <= r_c_side;
            r_dd[0]      <= r_c_total;
            r_dj[0].rem  <= 33'd0;
            r_dj[0].nq   <= d_num[63:0];
            r_dsa[0].rem <= 33'd0;
            r_dsa[0].nq  <= {16'd0, r_c_ima, 16'd0};
            r_dsb[0].rem <= 33'd0;
            r_dsb[0].nq  <= {16'd0, r_c_imb, 16'd0};
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_ds[k]  <= r_ds[k-1];
                r_dd[k]  <= r_dd[k-1];
                r_dj[k]  <= div_step(r_dj[k-1], r_dd[k-1]);
                r_dsa[k] <= div_step(r_dsa[k-1], r_dd[k-1]);
                r_dsb[k] <= div_step(r_dsb[k-1], r_dd[k-1]);
            end
        end
    end

    // Stage E: share products and the impulse product in two partial products.
    t_side       e_side;
    logic [63:0] e_jm;
    logic [16:0] e_sa, e_sb;
    logic [15:0] e_anx, e_any;

    assign e_side = r_ds[DIV_STEPS];
    assign e_jm   = r_dj[DIV_STEPS].nq;
    assign e_sa   = r_dsa[DIV_STEPS].nq[16:0];
    assign e_sb   = r_dsb[DIV_STEPS].nq[16:0];
    assign e_anx  = abs16(e_side.nx);
    assign e_any  = abs16(e_side.ny);

    logic        r_e_valid;
    t_side       r_e_side;
    logic [63:0] r_e_sax, r_e_say, r_e_sbx, r_e_sby;
    logic [47:0] r_e_jlo_x, r_e_jlo_y;
    logic [40:0] r_e_jhi_x, r_e_jhi_y;
    logic        r_e_big;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side  <= e_side;
            r_e_sax   <= e_side.penx * e_sa;
            r_e_say   <= e_side.peny * e_sa;
            r_e_sbx   <= e_side.penx * e_sb;
            r_e_sby   <= e_side.peny * e_sb;
            r_e_jlo_x <= e_jm[31:0] * e_anx;
            r_e_jlo_y <= e_jm[31:0] * e_any;
            r_e_jhi_x <= e_jm[56:32] * e_anx;
            r_e_jhi_y <= e_jm[56:32] * e_any;
            // A quotient this large saturates for any nonzero normal component.
            r_e_big   <= |e_jm[63:57];
        end
    end

    // Stage F: rounding, saturation and the skip cases into the output word.
    function automatic logic e_nonzero(logic signed [15:0] v);
        return v != 16'sd0;
    endfunction

    logic [63:0] f_rsax, f_rsay, f_rsbx, f_rsby;
    logic [72:0] f_jx, f_jy;
    logic [46:0] f_mjx, f_mjy;
    logic        f_ineg_x, f_ineg_y;
    logic [191:0] f_data;

    assign f_rsax = r_e_sax + 64'h2000_0000;
    assign f_rsay = r_e_say + 64'h2000_0000;
    assign f_rsbx = r_e_sbx + 64'h2000_0000;
    assign f_rsby = r_e_sby + 64'h2000_0000;
    assign f_jx   = {r_e_jhi_x, 32'd0} + 73'(r_e_jlo_x) + 73'h200_0000;
    assign f_jy   = {r_e_jhi_y, 32'd0} + 73'(r_e_jlo_y) + 73'h200_0000;

    always_comb begin
        f_mjx = f_jx[72:26];
        f_mjy = f_jy[72:26];
        if (r_e_big && e_nonzero(r_e_side.nx)) f_mjx = {47{1'b1}};
        if (r_e_big && e_nonzero(r_e_side.ny)) f_mjy = {47{1'b1}};
    end

    assign f_ineg_x = (r_e_side.dneg == r_e_side.nx[15]);
    assign f_ineg_y = (r_e_side.dneg == r_e_side.ny[15]);

    always_comb begin
        f_data = '0;
        if (r_e_side.status == ST_RESOLVED) begin
            f_data[31:0]    = sat32(r_e_side.nx[15], {13'd0, f_rsax[63:30]});
            f_data[63:32]   = sat32(r_e_side.ny[15], {13'd0, f_rsay[63:30]});
            f_data[95:64]   = sat32(r_e_side.nx[15], {13'd0, f_rsbx[63:30]});
            f_data[127:96]  = sat32(r_e_side.ny[15], {13'd0, f_rsby[63:30]});
            f_data[159:128] = sat32(f_ineg_x, f_mjx);
            f_data[191:160] = sat32(f_ineg_y, f_mjy);
        end
    end

    logic [191:0] r_out_data;
    t_status      r_out_status;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data   <= f_data;
            r_out_status <= r_e_side.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_dv        <= '0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_load) r_a_valid <= i_s_axis_tvalid;
            if (en) begin
                r_b_valid   <= r_a_valid;
                r_c_valid   <= r_b_valid;
                r_dv        <= {r_dv[DIV_STEPS-1:0], r_c_valid};
                r_e_valid   <= r_dv[DIV_STEPS];
                r_out_valid <= r_e_valid;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

/* rtl/core/cir_checker.sv */
// Port-level checker for the contact impulse resolver, bound to the top level.
`include "contact_impulse_resolver_core_macros.svh"

module cir_checker
    import cir_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [191:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser
);

    // Only the three defined status codes may leave the block.
    `CIR_ASSERT_NOW(a_status_legal, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tuser == ST_RESOLVED || o_m_axis_tuser == ST_NO_BODY || o_m_axis_tuser == ST_IMMOVABLE))

    // A skipped contact carries no correction and no impulse.
    `CIR_ASSERT_NOW(a_skip_zero, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser != ST_RESOLVED), (o_m_axis_tdata == '0))

    // A result word that is not taken stays as it is.
    `CIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready), (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))

endmodule

bind contact_impulse_resolver_core cir_checker u_cir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* dv/contact_impulse_resolver_checker.sv */
// Checker that predicts and compares the words of the contact impulse resolver.
module contact_impulse_resolver_checker
    import cir_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [14:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    // inv_mass_a, inv_mass_b, vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y,
    // penetration, one zero pad bit
    input  logic [255:0] i_s_axis_tdata,
    // body_a_present, body_b_present
    input  logic [1:0]   i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // shift_a_x, shift_a_y, shift_b_x, shift_b_y, impulse_x, impulse_y
    input  logic [191:0] i_m_axis_tdata,
    // status
    input  logic [1:0]   i_m_axis_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        t_status      status;
        logic [191:0] vec;
    } t_contact_result;

    t_contact_result expected_results[$];
    logic [14:0]     restitution_q = RESTITUTION_RST;
    string           field_names[6] = '{"shift_a_x", "shift_a_y", "shift_b_x",
                                        "shift_b_y", "impulse_x", "impulse_y"};

    initial o_fail_count = 0;
    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [191:0] got,
                                   input logic [191:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [31:0] saturate_q16(logic neg, logic [63:0] m);
        if (m == 64'd0) return 32'd0;
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - m[31:0];
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [31:0] shift_part(longint n, logic [63:0] pen,
                                               logic [63:0] share);
        logic [63:0] m;
        m = magnitude(n) * pen * share;
        m = (m + (64'd1 << 29)) >> 30;
        return saturate_q16(n < 0, m);
    endfunction

    function automatic logic [31:0] impulse_part(logic dneg, logic [63:0] jm, longint n);
        logic [63:0] an;
        logic [63:0] m;
        an = magnitude(n);
        if (an == 0 || jm == 0) return 32'd0;
        // Products that would overflow 64 bits are pinned far above the saturation point.
        if (jm > (64'h8000_0000_0000_0000 / an)) m = 64'd1 << 37;
        else m = (jm * an + (64'd1 << 25)) >> 26;
        return saturate_q16(dneg == (n < 0), m);
    endfunction

    function automatic t_contact_result resolve_contact(logic [1:0] u, logic [255:0] d,
                                                        logic [14:0] e);
        t_contact_result r;
        logic [63:0] ima, imb, total, pen, sa, sb, jm;
        longint vax, vay, vbx, vby, nx, ny, dot;
        ima = 64'(d[31:0]);
        imb = 64'(d[63:32]);
        vax = $signed(d[95:64]);
        vay = $signed(d[127:96]);
        vbx = $signed(d[159:128]);
        vby = $signed(d[191:160]);
        nx  = $signed(d[207:192]);
        ny  = $signed(d[223:208]);
        pen = 64'(d[254:224]);
        total = ima + imb;
        r = '0;
        if (!u[0] || !u[1]) begin
            r.status = ST_NO_BODY;
        end else if (total == 0) begin
            r.status = ST_IMMOVABLE;
        end else begin
            r.status = ST_RESOLVED;
            sa  = (ima << 16) / total;
            sb  = (imb << 16) / total;
            dot = (vbx - vax) * nx + (vby - vay) * ny;
            jm  = (magnitude(dot) * (64'd16384 + 64'(e))) / total;
            r.vec[31:0]    = shift_part(nx, pen, sa);
            r.vec[63:32]   = shift_part(ny, pen, sa);
            r.vec[95:64]   = shift_part(nx, pen, sb);
            r.vec[127:96]  = shift_part(ny, pen, sb);
            r.vec[159:128] = impulse_part(dot < 0, jm, nx);
            r.vec[191:160] = impulse_part(dot < 0, jm, ny);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_contact_result want;
        if (!i_rst_n) begin
            restitution_q <= RESTITUTION_RST;
        end else begin
            if (i_cfg_wr_en) restitution_q <= i_cfg_wr_data;
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.push_back(resolve_contact(i_s_axis_tuser, i_s_axis_tdata,
                                                           restitution_q));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", i_m_axis_tdata, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_axis_tuser !== want.status)
                        report_mismatch("status", 192'(i_m_axis_tuser), 192'(want.status));
                    for (int k = 0; k < 6; k++)
                        if (i_m_axis_tdata[32*k +: 32] !== want.vec[32*k +: 32])
                            report_mismatch(field_names[k], 192'(i_m_axis_tdata[32*k +: 32]),
                                            192'(want.vec[32*k +: 32]));
                end
            end
        end
    end

endmodule

/* dv/tb_contact_impulse_resolver_core.sv */
// Stimulus and verdict for the contact impulse resolver core.
module tb_contact_impulse_resolver_core;
    import cir_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [14:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           hold_left = 0;
    int           cycle_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    contact_impulse_resolver_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    contact_impulse_resolver_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_contact(input logic pa, input logic pb, input logic [31:0] ima,
                                input logic [31:0] imb, input logic [31:0] vax,
                                input logic [31:0] vay, input logic [31:0] vbx,
                                input logic [31:0] vby, input logic [15:0] nx,
                                input logic [15:0] ny, input logic [30:0] pen);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {pb, pa};
        s_tdata  <= {1'b0, pen, ny, nx, vby, vbx, vay, vax, imb, ima};
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return $urandom_range(1, 32'h2_0000);
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom_range(32'h100, 32'h40_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(32'h20_0000)) - 32'sh10_0000);
        endcase
    endfunction

    function automatic logic [15:0] pick_normal();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'd16384 : 16'hC000;
            2:       return 16'd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [30:0] pick_depth();
        case ($urandom_range(3))
            0:       return 31'($urandom);
            1:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(32'h4_0000));
        endcase
    endfunction

    task automatic send_random(input int count);
        logic pa, pb;
        for (int i = 0; i < count; i++) begin
            pa = ($urandom_range(15) != 0);
            pb = ($urandom_range(15) != 0);
            send_contact(pa, pb, pick_mass(), pick_mass(), pick_velocity(), pick_velocity(),
                         pick_velocity(), pick_velocity(), pick_normal(), pick_normal(),
                         pick_depth());
        end
    endtask

    // The register may only change once every word in flight has come out.
    // The task first waits on the clock so that the last accepted word is already counted.
    task automatic set_restitution(input logic [14:0] value);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed contacts at the reset restitution.
        send_contact(0, 1, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 16'd16384, 0, 31'h1_0000);
        send_contact(1, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 16'd16384, 0, 31'h1_0000);
        send_contact(0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 16'd16384, 0, 31'h1_0000);
        send_contact(1, 1, 0, 0, 32'h1_0000, 0, 0, 0, 16'd16384, 0, 31'h1_0000);
        send_contact(1, 1, 0, 32'h1_0000, 32'h2_0000, 0, 0, 0, 16'd16384, 0, 31'h1_0000);
        send_contact(1, 1, 32'h1_0000, 0, 32'h2_0000, 32'h1_0000, 0, 0, 16'd11585, 16'd11585,
                     31'h8000);
        send_contact(1, 1, 32'h1_0000, 32'h3_0000, 0, 0, 32'h2_0000, 0, 16'd16384, 0, 31'h1_0000);
        send_contact(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 31'h7FFF_FFFF);
        send_contact(1, 1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     16'h7FFF, 16'h8000, 31'h7FFF_FFFF);
        send_contact(1, 1, 1, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 16'h8000, 0, 31'h7FFF_FFFF);
        send_contact(1, 1, 32'h1_0000, 32'h1_0000, 32'h1234_5678, 32'h8765_4321, 32'h1, 32'hF,
                     0, 0, 31'h7FFF_FFFF);
        send_contact(1, 1, 32'h2_0000, 32'h1_0000, 0, 0, 0, 0, 16'hC000, 16'h4000, 0);
        send_contact(1, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 16'h7FFF,
                     16'h7FFF, 31'h1);

        set_restitution(15'd0);
        send_contact(1, 1, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 16'd16384, 0, 31'h1_0000);
        send_random(30);
        set_restitution(15'd32767);
        send_contact(1, 1, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     16'h8000, 16'h8000, 31'h7FFF_FFFF);
        send_random(30);
        set_restitution(15'd16384);
        send_random(200);

        sender_idle_pct = 50;
        set_restitution(15'($urandom_range(16384)));
        send_random(190);

        sender_idle_pct = 0;
        receiver_stall_pct = 50;
        set_restitution(RESTITUTION_RST);
        send_random(190);

        sender_idle_pct = 12;
        receiver_stall_pct = 12;
        set_restitution(15'($urandom));
        send_random(190);

        // Long hold-off on the result side so the pipeline fills and input stalls.
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        set_restitution(15'($urandom_range(16384)));
        hold_left = 400;
        send_random(200);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
